@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the punch-in audio effect.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/pia_pkg.sv @@
// Package with types and constants of the punch-in audio effect.
`timescale 1ns / 1ps
`default_nettype none
package pia_pkg;
	typedef logic signed [15:0] sample_t;
	typedef logic [3:0] effect_t;
	typedef logic [12:0] step_t;
	localparam effect_t FX_NONE = 4'd0;
	localparam effect_t FX_LOOP16 = 4'd1;
	localparam effect_t FX_LOOP12 = 4'd2;
	localparam effect_t FX_SHORT = 4'd3;
	localparam effect_t FX_SHORTEST = 4'd4;
	localparam effect_t FX_UNISON = 4'd5;
	localparam effect_t FX_UNISON_LOW = 4'd6;
	localparam effect_t FX_OCT_UP = 4'd7;
	localparam effect_t FX_OCT_DOWN = 4'd8;
	localparam effect_t FX_REVERSE = 4'd9;
	localparam effect_t FX_STUTTER4 = 4'd10;
	localparam effect_t FX_STUTTER3 = 4'd11;
	localparam effect_t FX_RETRIG = 4'd12;
	localparam effect_t FX_SCRATCH = 4'd13;
	localparam effect_t FX_SCRATCH_FAST = 4'd14;
	localparam effect_t FX_GATE68 = 4'd15;
	localparam int UNISON_DELAY = 110;
	localparam int UNISON_LOW_DELAY = 331;
	localparam int STEP_RESET = 2756;
	localparam int STEP_MIN = 16;
endpackage
`default_nettype wire

@@ hw/rtl/pia_if.sv @@
// Valid/ready channel interface carrying one item.
`timescale 1ns / 1ps
`default_nettype none
interface pia_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/punch_in_audio_effect_core.sv @@
// Top level of the punch-in audio effect with history memory and shared divider.
// An accepted item passes through PREP, one pass of the 32-bit restoring divider, MID,
// ADDR, READ, LOAD, CALC and OUT; stutter and retrigger take a second divider pass.
// No new item is accepted until the output has taken the result.
// After reset a clearing pass zeroes the history; no item is accepted meanwhile,
// configuration writes are. Control state clears on arst_n.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module punch_in_audio_effect_core #(
	parameter int HISTORY_FRAMES = 16384,
	parameter int MAX_STEP_FRAMES = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	pia_if.sink in_ch,
	pia_if.source out_ch,
	pia_if.sink cfg_ch
);
	import pia_pkg::*;
	localparam int AW = $clog2(HISTORY_FRAMES);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PREP, S_DIV1, S_MID, S_DIV2, S_ADDR, S_READ, S_LOAD, S_CALC, S_OUT
	} state_t;
	state_t state_q;

	logic [AW-1:0] wpos_q, clr_q, raddr_q;
	logic [31:0] phase_q;
	effect_t active_q;
	step_t step_q;
	sample_t x_q, rd_q, y_q;
	logic [31:0] dvd_q, quo_q, rem_q, dvs_q;
	logic [5:0] cnt_q;
	logic [31:0] slice_q, delay_q;
	logic gate_q;
	logic [31:0] r1_q;
	logic [15:0] mem [HISTORY_FRAMES];
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0] mem_wd;

	logic [31:0] step32, step2, half;
	logic [32:0] trial;
	logic [31:0] rem_sh;
	logic [12:0] cin;
	logic [29:0] third_p;
	logic [31:0] third;
	assign step32 = {19'd0, step_q};
	assign step2 = {18'd0, step_q, 1'b0};
	assign half = (step_q[12:1] == 12'd0) ? 32'd1 : {20'd0, step_q[12:1]};
	// A third of the step length by reciprocal multiplication, exact over the 13-bit range.
	assign third_p = 30'(step_q) * 30'd43691;
	assign third = {19'd0, third_p[29:17]};
	assign cin = (cfg_ch.data[12:0] < 13'(STEP_MIN)) ? 13'(STEP_MIN) :
		(cfg_ch.data[12:0] > 13'(MAX_STEP_FRAMES)) ? 13'(MAX_STEP_FRAMES) :
		cfg_ch.data[12:0];
	assign rem_sh = {rem_q[30:0], dvd_q[31]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = y_q;

	// Divisor for the first pass.
	function automatic logic [31:0] div1_of(effect_t e, logic [31:0] s, logic [31:0] s2,
		logic [31:0] h);
		unique case (e)
			FX_OCT_DOWN, FX_GATE68: div1_of = s2;
			FX_STUTTER4: div1_of = {2'd0, s[31:2]};
			FX_SCRATCH_FAST: div1_of = h;
			default: div1_of = s;
		endcase
	endfunction

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= sample_t'(mem[raddr_q]);
	end
	always_comb begin
		mem_we = (state_q == S_CLEAR) || (state_q == S_PREP);
		mem_wa = (state_q == S_CLEAR) ? clr_q : wpos_q;
		mem_wd = (state_q == S_CLEAR) ? 16'd0 : x_q;
	end

	logic [31:0] cap_w, dly_c;
	logic signed [16:0] sum_c;
	always_comb begin
		cap_w = (slice_q == 32'd0) ? 32'd0 : quo_q;
		dly_c = 32'd0;
		unique case (active_q)
			FX_LOOP16: dly_c = step32;
			FX_SHORT: dly_c = {20'd0, step_q[12:1]};
			FX_SHORTEST: dly_c = {21'd0, step_q[12:2]};
			FX_UNISON: dly_c = 32'(UNISON_DELAY);
			FX_UNISON_LOW: dly_c = 32'(UNISON_LOW_DELAY);
			default: dly_c = delay_q;
		endcase
		sum_c = 17'(x_q) + 17'(rd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			wpos_q <= '0;
			phase_q <= '0;
			active_q <= FX_NONE;
			step_q <= 13'(STEP_RESET);
		end else begin
			if (cfg_ch.valid) step_q <= cin;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(HISTORY_FRAMES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						x_q <= sample_t'(in_ch.data[15:0]);
						if (in_ch.data[19:16] != active_q) begin
							active_q <= in_ch.data[19:16];
							phase_q <= '0;
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					dvd_q <= (active_q == FX_LOOP12) ? {17'd0, step_q, 2'd0} : phase_q;
					dvs_q <= (active_q == FX_LOOP12) ? 32'd3 :
						(active_q == FX_STUTTER3) ? third :
						div1_of(active_q, step32, step2, half);
					slice_q <= (active_q == FX_STUTTER3) ? third :
						div1_of(active_q, step32, step2, half);
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 6'd32;
					state_q <= S_DIV1;
				end
				S_DIV1, S_DIV2: begin
					if (dvs_q == 32'd0) begin
						quo_q <= '0;
						rem_q <= '0;
						cnt_q <= '0;
					end else if (cnt_q != 6'd0) begin
						dvd_q <= {dvd_q[30:0], 1'b0};
						if (!trial[32]) begin
							rem_q <= trial[31:0];
							quo_q <= {quo_q[30:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[30:0], 1'b0};
						end
						cnt_q <= cnt_q - 1'b1;
					end
					if (cnt_q == 6'd0 || dvs_q == 32'd0)
						state_q <= (state_q == S_DIV1) ? S_MID : S_ADDR;
				end
				S_MID: begin
					r1_q <= quo_q;
					gate_q <= rem_q > ((step32 * 3) >> 1);
					unique case (active_q)
						FX_LOOP12: delay_q <= quo_q;
						FX_OCT_UP: delay_q <= step32 - 32'd1 - rem_q;
						FX_OCT_DOWN: delay_q <= {1'b0, rem_q[31:1]};
						FX_REVERSE: delay_q <= {rem_q[30:0], 1'b0};
						FX_SCRATCH: delay_q <= (rem_q + {rem_q[30:0], 1'b0}) >> 1;
						FX_SCRATCH_FAST: delay_q <= rem_q + {rem_q[30:0], 1'b0};
						default: delay_q <= '0;
					endcase
					if (active_q == FX_STUTTER4 || active_q == FX_STUTTER3 ||
						active_q == FX_RETRIG) begin
						dvd_q <= 32'(HISTORY_FRAMES);
						dvs_q <= slice_q;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 6'd32;
						state_q <= S_DIV2;
					end else state_q <= S_ADDR;
				end
				S_ADDR: begin
					if (active_q == FX_STUTTER4 || active_q == FX_STUTTER3 ||
						active_q == FX_RETRIG) begin
						delay_q <= (slice_q == 32'd0) ? 32'd0 :
							((cap_w > 32'd1 && r1_q > cap_w - 32'd1) ?
							(cap_w - 32'd1) * slice_q : r1_q * slice_q);
					end
					state_q <= S_READ;
				end
				S_READ: begin
					raddr_q <= wpos_q - ((dly_c >= 32'(HISTORY_FRAMES)) ?
						AW'(HISTORY_FRAMES - 1) : dly_c[AW-1:0]);
					state_q <= S_LOAD;
				end
				S_LOAD: state_q <= S_CALC;
				S_CALC: state_q <= S_OUT;
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
						wpos_q <= wpos_q + 1'b1;
						phase_q <= phase_q + 32'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_CALC) begin
				unique case (active_q)
					FX_NONE: y_q <= x_q;
					FX_UNISON, FX_UNISON_LOW:
						y_q <= sample_t'((sum_c + 17'(sum_c[16])) >>> 1);
					FX_GATE68: y_q <= gate_q ? 16'sd0 : x_q;
					default: y_q <= rd_q;
				endcase
			end
		end
	end

	`ASSERT_IMPL(a_excl, clk, arst_n, !(in_ch.ready && out_ch.valid))
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
	`ASSERT_NEXT(a_acc, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
endmodule
`default_nettype wire
